/* src/imadec_pkg.sv */
// ----------------------------------------------------------------------------
// imadec_pkg
// Shared types, codes and tables for the IMA ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package imadec_pkg;

   // Opcodes of an input beat
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Result status codes, also used as the queued operation kind
   typedef logic [1:0] status_type;
   localparam status_type STATUS_SAMPLE = 2'd0;
   localparam status_type STATUS_LOADED = 2'd1;
   localparam status_type STATUS_REJECT = 2'd2;

   localparam int           IDX_BITS = 7;
   localparam int           QUEUE_DEPTH = 2;
   localparam logic [IDX_BITS-1:0] IDX_MAX = 7'd88;
   localparam logic signed [17:0] PRED_MAX = 18'sd32767;
   localparam logic signed [17:0] PRED_MIN = -18'sd32768;

   // Step size per step index
   localparam logic [14:0] STEP_TABLE [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // Step index adjustment per code
   localparam logic signed [4:0] INDEX_MOVE [0:15] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

   // Classified operation held in the queue
   typedef struct packed {
      status_type           kind;
      logic signed [15:0]   predictor;
      logic [IDX_BITS-1:0]  step_index;
      logic [3:0]           code_nibble;
   } op_type;

   // Queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* src/imadec_ifs.sv */
// ----------------------------------------------------------------------------
// imadec channel interfaces
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface imadec_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [15:0] start_predictor;
   logic signed [15:0] start_step_index;
   logic [3:0]         code_nibble;

   modport source (output valid, opcode, start_predictor, start_step_index, code_nibble,
                   input ready);
   modport sink   (input valid, opcode, start_predictor, start_step_index, code_nibble,
                   output ready);
endinterface

interface imadec_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic [1:0]         status;

   modport source (output valid, sample, status, input ready);
   modport sink   (input valid, sample, status, output ready);
endinterface

/* src/imadec_front.sv */
// ----------------------------------------------------------------------------
// imadec_front
// Accept request beats and classify them into decode, load or reject.
// ----------------------------------------------------------------------------
module imadec_front (
   imadec_req_if.sink            req_chan,
   input  imadec_pkg::qstat_type qstat,
   output logic                  push_en,
   output imadec_pkg::op_type    push_data
);

   logic idx_ok;

   // Take a beat whenever the queue has room
   assign req_chan.ready = !qstat.full;
   assign push_en        = req_chan.valid && !qstat.full;

   // Check the start step index against 0..88 (negative values fail the high bits)
   assign idx_ok = (req_chan.start_step_index[15:imadec_pkg::IDX_BITS] == '0) &&
                   (req_chan.start_step_index[imadec_pkg::IDX_BITS-1:0] <= imadec_pkg::IDX_MAX);

   // Classify the beat
   always_comb begin
      push_data.predictor   = req_chan.start_predictor;
      push_data.step_index  = req_chan.start_step_index[imadec_pkg::IDX_BITS-1:0];
      push_data.code_nibble = req_chan.code_nibble;
      if (req_chan.opcode == imadec_pkg::OP_DECODE) begin
         push_data.kind = imadec_pkg::STATUS_SAMPLE;
      end else if (idx_ok) begin
         push_data.kind = imadec_pkg::STATUS_LOADED;
      end else begin
         push_data.kind = imadec_pkg::STATUS_REJECT;
      end
   end

endmodule

/* src/imadec_queue.sv */
// ----------------------------------------------------------------------------
// imadec_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module imadec_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  imadec_pkg::op_type     push_data,
   input  logic                   pop_en,
   output imadec_pkg::op_type     pop_data,
   output imadec_pkg::qstat_type  qstat
);

   imadec_pkg::op_type entry_ff [imadec_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign qstat.full  = (count_ff == 2'(imadec_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == 2'd0);
   assign pop_data    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_en;
      rd_ptr_in = rd_ptr_ff ^ pop_en;
      count_in  = count_ff + 2'(push_en) - 2'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/imadec_back.sv */
// ----------------------------------------------------------------------------
// imadec_back
// Execute queued operations against the channel state and register results.
// ----------------------------------------------------------------------------
module imadec_back (
   input  logic                  clock,
   input  logic                  reset,
   input  imadec_pkg::op_type    op,
   input  imadec_pkg::qstat_type qstat,
   output logic                  pop_en,
   imadec_rsp_if.source          rsp_chan
);

   logic signed [15:0]                predictor_ff, predictor_in;
   logic [imadec_pkg::IDX_BITS-1:0]   step_index_ff, step_index_in;
   logic                              out_valid_ff, out_valid_in;
   logic signed [15:0]                sample_ff, sample_in;
   imadec_pkg::status_type            status_ff, status_in;

   logic [imadec_pkg::IDX_BITS-1:0]   si;
   logic [14:0]                       step;
   logic [16:0]                       diff;
   logic signed [17:0]                diff_s;
   logic signed [17:0]                sum;
   logic signed [15:0]                pred_sat;
   logic signed [4:0]                 move;
   logic signed [8:0]                 ni;
   logic [imadec_pkg::IDX_BITS-1:0]   ni_clamp;

   // Pop when the output register is free or being drained
   assign pop_en = !qstat.empty && (!out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.sample = sample_ff;
   assign rsp_chan.status = status_ff;

   // Build the difference from the step size
   always_comb begin
      si   = (step_index_ff > imadec_pkg::IDX_MAX) ? imadec_pkg::IDX_MAX : step_index_ff;
      step = imadec_pkg::STEP_TABLE[si];
      diff = {5'd0, step[14:3]}
           + (op.code_nibble[2] ? {2'd0, step} : 17'd0)
           + (op.code_nibble[1] ? {3'd0, step[14:1]} : 17'd0)
           + (op.code_nibble[0] ? {4'd0, step[14:2]} : 17'd0);
      diff_s = op.code_nibble[3] ? -$signed({1'b0, diff}) : $signed({1'b0, diff});
   end

   // Add to the predictor and saturate to 16 bits
   always_comb begin
      sum = $signed({{2{predictor_ff[15]}}, predictor_ff}) + diff_s;
      if (sum > imadec_pkg::PRED_MAX) begin
         pred_sat = 16'sd32767;
      end else if (sum < imadec_pkg::PRED_MIN) begin
         pred_sat = -16'sd32768;
      end else begin
         pred_sat = sum[15:0];
      end
   end

   // Move the step index and clamp to 0..88
   always_comb begin
      move = imadec_pkg::INDEX_MOVE[op.code_nibble];
      ni   = $signed({2'b00, si}) + $signed({{4{move[4]}}, move});
      if (ni < 9'sd0) begin
         ni_clamp = '0;
      end else if (ni > $signed({2'b00, imadec_pkg::IDX_MAX})) begin
         ni_clamp = imadec_pkg::IDX_MAX;
      end else begin
         ni_clamp = ni[imadec_pkg::IDX_BITS-1:0];
      end
   end

   // Execute the popped operation
   always_comb begin
      predictor_in  = predictor_ff;
      step_index_in = step_index_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      sample_in     = sample_ff;
      status_in     = status_ff;
      if (pop_en) begin
         out_valid_in = 1'b1;
         status_in    = op.kind;
         sample_in    = '0;
         unique case (op.kind)
            imadec_pkg::STATUS_SAMPLE: begin
               predictor_in  = pred_sat;
               step_index_in = ni_clamp;
               sample_in     = pred_sat;
            end
            imadec_pkg::STATUS_LOADED: begin
               predictor_in  = op.predictor;
               step_index_in = op.step_index;
            end
            default: begin
               // rejected load: hold the state
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         predictor_ff  <= '0;
         step_index_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         predictor_ff  <= predictor_in;
         step_index_ff <= step_index_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      status_ff <= status_in;
   end

endmodule

/* src/ima_adpcm_nibble_decoder.sv */
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder
// IMA ADPCM decoder for one channel: load start state, decode 4-bit codes.
// ----------------------------------------------------------------------------
//  channel   | dir | beat content
//  ----------+-----+----------------------------------------------------------
//  req_chan  | in  | opcode, start_predictor, start_step_index, code_nibble
//  rsp_chan  | out | sample, status
//
//  One request per cycle sustained while responses are not stalled; a result
//  passes through a queue entry, then the output register. The decode path
//  (step table lookup, difference add and saturate) is combinational.
//  Synchronous reset clears predictor and step index to zero and empties
//  the queue. A stalled response holds in the output register while the
//  two-entry queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder (
   input  logic          clock,
   input  logic          reset,
   imadec_req_if.sink    req_chan,
   imadec_rsp_if.source  rsp_chan
);

   imadec_pkg::op_type    push_data;
   imadec_pkg::op_type    pop_data;
   imadec_pkg::qstat_type qstat;
   logic                  push_en;
   logic                  pop_en;

   imadec_front u_front (
      .req_chan  (req_chan),
      .qstat     (qstat),
      .push_en   (push_en),
      .push_data (push_data)
   );

   imadec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .pop_en    (pop_en),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   imadec_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (pop_data),
      .qstat    (qstat),
      .pop_en   (pop_en),
      .rsp_chan (rsp_chan)
   );

endmodule
